FILE: sv/rc6_block_cipher_top_defines.svh
// Assertion macros for the RC6 block cipher top level.
// Used by rc6_block_cipher_top only.
`ifndef RC6_BLOCK_CIPHER_TOP_DEFINES_SVH
`define RC6_BLOCK_CIPHER_TOP_DEFINES_SVH
`define RC6_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define RC6_ASSERT_NXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

FILE: sv/rc6_pkg.sv
// Package for the RC6 block cipher: constants, types, functions.
// No dependencies.
`default_nettype none
package rc6_pkg;
   localparam int MaxRounds = 20;
   localparam int NumKeys = 2 * MaxRounds + 4;
   localparam int KeyAw = $clog2(NumKeys);
   localparam int RndW = $clog2(MaxRounds + 1);
   localparam logic [31:0] P32 = 32'hB7E15163;
   localparam logic [31:0] Q32 = 32'h9E3779B9;
   localparam logic [2:0] CSR_KEY0 = 3'd0;
   localparam logic [2:0] CSR_KEY1 = 3'd1;
   localparam logic [2:0] CSR_KEY2 = 3'd2;
   localparam logic [2:0] CSR_KEY3 = 3'd3;
   localparam logic [2:0] CSR_KSIZE = 3'd4;
   localparam logic [2:0] CSR_ROUNDS = 3'd5;
   localparam logic OP_ENC = 1'b0;
   localparam logic OP_DEC = 1'b1;

   typedef struct packed {
      logic       op;
      logic [63:0] lo;
      logic [63:0] hi;
   } req_type;

   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_INIT, ST_MIX, ST_PRE, ST_RND, ST_POST, ST_OUT
   } state_type;

   function automatic logic [31:0] rol32(input logic [31:0] w, input logic [4:0] s);
      logic [63:0] d;
      d = {w, w} << s;
      return d[63:32];
   endfunction

   function automatic logic [31:0] ror32(input logic [31:0] w, input logic [4:0] s);
      logic [63:0] d;
      d = {w, w} >> s;
      return d[31:0];
   endfunction
endpackage
`default_nettype wire

FILE: sv/rc6_stream_if.sv
// Valid/ready channel carrying a packed payload.
// Depends on nothing.
`default_nettype none
interface rc6_stream_if #(parameter int Width = 129);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/rc6_block_cipher_top.sv
// RC6-32 block cipher top level: ports, front queue and engine.
// Depends on rc6_pkg, rc6_stream_if, rc6_front, rc6_engine and the defines header.
`default_nettype none
`include "rc6_block_cipher_top_defines.svh"
// Encrypts or decrypts one 128-bit block per request in ECB fashion. The round
// engine does one round per cycle, using two 32x32 multipliers per direction.
// After reset or any csr write to indices 0 to 5, the first request first runs
// the key schedule: constant fill, then mixing, with each mixing step waiting
// for the key memory read. Write csr registers only while idle.
module rc6_block_cipher_top (
   input  wire logic        clock,
   input  wire logic        reset,
   rc6_stream_if.sink       req,
   rc6_stream_if.source     rsp,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_idx,
   input  wire logic [63:0] csr_data
);
   logic q_valid, q_pop, busy;
   rc6_pkg::req_type q_data, in_data;
   rc6_pkg::rsp_type out_data;

   assign in_data = rc6_pkg::req_type'(req.payload);
   assign rsp.payload = out_data;

   rc6_front u_front (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready), .in_data,
      .q_valid, .q_pop, .q_data
   );

   rc6_engine u_engine (
      .clock, .reset, .csr_we, .csr_idx, .csr_data, .q_valid, .q_pop, .q_data,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data, .busy
   );

   `RC6_ASSERT_IMP(a_pop_valid, clock, reset, q_pop, q_valid, "pop from empty queue")
   `RC6_ASSERT_NXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid,
                   "response dropped")
   `RC6_ASSERT_IMP(a_busy_rsp, clock, reset, rsp.valid, busy, "response while not busy")
endmodule
`default_nettype wire

FILE: sv/rc6_front.sv
// Front: two-entry request queue between the input channel and the engine.
// Depends on rc6_pkg.
`default_nettype none
module rc6_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire rc6_pkg::req_type in_data,
   output logic                 q_valid,
   input  wire logic            q_pop,
   output rc6_pkg::req_type     q_data
);
   rc6_pkg::req_type mem_ff [2];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = mem_ff[rd_ff];

   always_comb begin
      rd_in = rd_ff ^ q_pop;
      wr_in = wr_ff ^ push;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule
`default_nettype wire

FILE: sv/rc6_engine.sv
// Back end: key schedule and round engine, one round per cycle.
// Depends on rc6_pkg.
`default_nettype none
module rc6_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_idx,
   input  wire logic [63:0]      csr_data,
   input  wire logic             q_valid,
   output logic                  q_pop,
   input  wire rc6_pkg::req_type q_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output rc6_pkg::rsp_type      out_data,
   output logic                  busy
);
   logic [31:0] rk_mem [rc6_pkg::NumKeys];
   logic [31:0] lw_ff [8];
   logic [63:0] kw_ff [4];
   logic [1:0] ksz_ff;
   logic [4:0] rcnt_ff;
   logic ready_ff, ready_in;
   rc6_pkg::state_type st_ff, st_in;
   logic [rc6_pkg::KeyAw-1:0] i_ff, i_in, n_m1;
   logic [2:0] j_ff, j_in, c_m1;
   logic [8:0] s_ff, s_in;
   logic [7:0] v_m1;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic [31:0] wa_ff, wb_ff, wc_ff, wd_ff, wa_in, wb_in, wc_in, wd_in;
   logic [rc6_pkg::RndW-1:0] k_ff, k_in, r_eff;
   logic op_ff, op_in;
   logic [31:0] rk_q, rk1_q;
   logic [rc6_pkg::KeyAw-1:0] ra0, ra1;
   logic rk_we;
   logic [rc6_pkg::KeyAw-1:0] rk_wa;
   logic [31:0] rk_wd;
   logic ov_ff, ov_in;
   rc6_pkg::rsp_type od_ff;
   logic [31:0] sb, tb, td, tt, uu, na, nc;

   assign r_eff = (rcnt_ff == 5'd0) ? rc6_pkg::RndW'(1) :
                  (rcnt_ff > 5'(rc6_pkg::MaxRounds)) ? rc6_pkg::RndW'(rc6_pkg::MaxRounds) :
                  rc6_pkg::RndW'(rcnt_ff);
   assign n_m1 = rc6_pkg::KeyAw'({r_eff, 1'b0} + 3);
   assign v_m1 = 8'(3 * ({1'b0, r_eff} * 2 + 4) - 1);
   assign c_m1 = (ksz_ff == 2'd0) ? 3'd3 : (ksz_ff == 2'd1) ? 3'd5 : 3'd7;

   // mixing step
   logic [31:0] na_m, nb_m;
   assign na_m = rc6_pkg::rol32(rk_q + a_ff + b_ff, 5'd3);
   assign sb = na_m + b_ff;
   assign nb_m = rc6_pkg::rol32(lw_ff[j_ff] + sb, sb[4:0]);

   // round function
   assign tb = wb_ff * {wb_ff[30:0], 1'b1};
   assign td = wd_ff * {wd_ff[30:0], 1'b1};
   assign tt = rc6_pkg::rol32(tb, 5'd5);
   assign uu = rc6_pkg::rol32(td, 5'd5);
   assign na = rc6_pkg::rol32(wa_ff ^ tt, uu[4:0]) + rk_q;
   assign nc = rc6_pkg::rol32(wc_ff ^ uu, tt[4:0]) + rk1_q;

   // decrypt round on rotated words
   logic [31:0] dt, du, dtb, dtd, da, dc;
   assign dtb = wa_ff * {wa_ff[30:0], 1'b1};
   assign dtd = wc_ff * {wc_ff[30:0], 1'b1};
   assign dt = rc6_pkg::rol32(dtb, 5'd5);
   assign du = rc6_pkg::rol32(dtd, 5'd5);
   assign dc = rc6_pkg::ror32(wb_ff - rk1_q, dt[4:0]) ^ du;
   assign da = rc6_pkg::ror32(wd_ff - rk_q, du[4:0]) ^ dt;

   always_comb begin
      ra0 = i_ff;
      ra1 = i_ff + 1'b1;
      if (st_ff == rc6_pkg::ST_PRE || st_ff == rc6_pkg::ST_RND ||
          st_ff == rc6_pkg::ST_POST) begin
         ra0 = {k_ff, 1'b0};
         ra1 = {k_ff, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      rk_q <= rk_mem[ra0];
      rk1_q <= rk_mem[ra1];
      if (rk_we) rk_mem[rk_wa] <= rk_wd;
   end

   assign busy = (st_ff != rc6_pkg::ST_IDLE) || ov_ff;
   assign out_valid = ov_ff;
   assign out_data = od_ff;

   always_comb begin
      st_in = st_ff; i_in = i_ff; j_in = j_ff; s_in = s_ff;
      a_in = a_ff; b_in = b_ff; k_in = k_ff; op_in = op_ff;
      wa_in = wa_ff; wb_in = wb_ff; wc_in = wc_ff; wd_in = wd_ff;
      ready_in = ready_ff; q_pop = 1'b0;
      rk_we = 1'b0; rk_wa = i_ff; rk_wd = rk_q;
      ov_in = ov_ff && !out_ready;
      unique case (st_ff)
         rc6_pkg::ST_IDLE: begin
            i_in = '0;
            if (q_valid && !ready_ff) begin
               st_in = rc6_pkg::ST_INIT; i_in = '0;
            end else if (q_valid && !ov_ff) begin
               q_pop = 1'b1; op_in = q_data.op;
               wa_in = q_data.lo[31:0]; wb_in = q_data.lo[63:32];
               wc_in = q_data.hi[31:0]; wd_in = q_data.hi[63:32];
               k_in = (q_data.op == rc6_pkg::OP_ENC) ? '0 : r_eff + 1'b1;
               st_in = rc6_pkg::ST_PRE;
            end
         end
         rc6_pkg::ST_INIT: begin
            rk_we = 1'b1; rk_wa = i_ff;
            rk_wd = rc6_pkg::P32 + 32'(i_ff) * rc6_pkg::Q32;
            i_in = i_ff + 1'b1;
            if (i_ff == n_m1) begin
               i_in = '0; j_in = '0; s_in = '0; a_in = '0; b_in = '0;
               st_in = rc6_pkg::ST_MIX;
            end
         end
         rc6_pkg::ST_MIX: begin
            // rk_q valid only in the odd phase: use s_ff[0] as phase
            if (s_ff[0]) begin
               rk_we = 1'b1; rk_wa = i_ff; rk_wd = na_m;
               a_in = na_m; b_in = nb_m;
               i_in = (i_ff == n_m1) ? '0 : i_ff + 1'b1;
               j_in = (j_ff == c_m1) ? '0 : j_ff + 1'b1;
            end
            s_in = s_ff + 1'b1;
            if (s_ff == {v_m1, 1'b1}) begin
               ready_in = 1'b1; st_in = rc6_pkg::ST_IDLE;
            end
         end
         rc6_pkg::ST_PRE: begin
            st_in = rc6_pkg::ST_RND;
            if (op_ff == rc6_pkg::OP_ENC) k_in = k_ff + 1'b1;
            else k_in = k_ff - 1'b1;
         end
         rc6_pkg::ST_RND: begin
            // key pair for k_ff-1 (enc) or k_ff+1 (dec) is in rk_q and rk1_q
            if (op_ff == rc6_pkg::OP_ENC) begin
               if (k_ff == rc6_pkg::RndW'(1)) begin
                  wb_in = wb_ff + rk_q; wd_in = wd_ff + rk1_q;
               end else if (k_ff == r_eff + 2'd2) begin
                  wa_in = wa_ff + rk_q; wc_in = wc_ff + rk1_q;
                  st_in = rc6_pkg::ST_OUT;
               end else begin
                  wa_in = wb_ff; wb_in = nc; wc_in = wd_ff; wd_in = na;
               end
               k_in = k_ff + 1'b1;
            end else begin
               if (k_ff == r_eff) begin
                  wa_in = wa_ff - rk_q; wc_in = wc_ff - rk1_q;
               end else begin
                  wa_in = da; wb_in = wa_ff; wc_in = dc; wd_in = wc_ff;
               end
               if (k_ff == '1) begin
                  wb_in = wb_ff - rk_q; wd_in = wd_ff - rk1_q;
                  wa_in = wa_ff; wc_in = wc_ff;
                  st_in = rc6_pkg::ST_OUT;
               end
               k_in = k_ff - 1'b1;
            end
         end
         rc6_pkg::ST_POST: st_in = rc6_pkg::ST_OUT;
         rc6_pkg::ST_OUT: begin
            if (!ov_ff) begin
               ov_in = 1'b1; st_in = rc6_pkg::ST_IDLE;
            end
         end
         default: st_in = rc6_pkg::ST_IDLE;
      endcase
      if (csr_we && csr_idx <= rc6_pkg::CSR_ROUNDS) ready_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= rc6_pkg::ST_IDLE;
         ready_ff <= 1'b0;
         ov_ff <= 1'b0;
         kw_ff[0] <= '0; kw_ff[1] <= '0; kw_ff[2] <= '0; kw_ff[3] <= '0;
         ksz_ff <= 2'd0;
         rcnt_ff <= 5'd20;
      end else begin
         st_ff <= st_in;
         ready_ff <= ready_in;
         ov_ff <= ov_in;
         if (csr_we) begin
            unique case (csr_idx)
               rc6_pkg::CSR_KEY0: kw_ff[0] <= csr_data;
               rc6_pkg::CSR_KEY1: kw_ff[1] <= csr_data;
               rc6_pkg::CSR_KEY2: kw_ff[2] <= csr_data;
               rc6_pkg::CSR_KEY3: kw_ff[3] <= csr_data;
               rc6_pkg::CSR_KSIZE: ksz_ff <= csr_data[1:0];
               rc6_pkg::CSR_ROUNDS: rcnt_ff <= csr_data[4:0];
               default: ;
            endcase
         end
      end
      i_ff <= i_in; j_ff <= j_in; s_ff <= s_in; a_ff <= a_in; b_ff <= b_in;
      k_ff <= k_in; op_ff <= op_in;
      wa_ff <= wa_in; wb_ff <= wb_in; wc_ff <= wc_in; wd_ff <= wd_in;
      if (st_ff == rc6_pkg::ST_IDLE && st_in == rc6_pkg::ST_INIT) begin
         for (int q = 0; q < 4; q++) begin
            lw_ff[2*q] <= kw_ff[q][31:0];
            lw_ff[2*q+1] <= kw_ff[q][63:32];
         end
      end else if (st_ff == rc6_pkg::ST_MIX && s_ff[0]) begin
         lw_ff[j_ff] <= nb_m;
      end
      if (st_ff == rc6_pkg::ST_OUT && !ov_ff) begin
         od_ff.lo <= {wb_ff, wa_ff};
         od_ff.hi <= {wd_ff, wc_ff};
      end
   end
endmodule
`default_nettype wire
